// File: design/pmts_pkg.sv
package pmts_pkg;

	localparam int unsigned EntryW = 64;
	localparam int unsigned PatW = 64;
	localparam int unsigned SlotW = 8;
	localparam int unsigned NumSlots = 8;
	localparam int unsigned TypeW = 3;
	localparam int unsigned IdxW = 3;

	localparam logic [PatW-1:0] PAT_RESET = 64'h0007_0406_0007_0406;

	localparam int unsigned BIT_PWT = 3;
	localparam int unsigned BIT_PCD = 4;
	localparam int unsigned BIT_PAT_LARGE = 12;
	localparam int unsigned BIT_PAT_SMALL = 7;

	typedef enum logic {
		OP_SET = 1'b0,
		OP_GET = 1'b1
	} op_t;

	typedef enum logic [1:0] {
		LVL_1G  = 2'd0,
		LVL_2M  = 2'd1,
		LVL_4K  = 2'd2,
		LVL_BAD = 2'd3
	} level_t;

	typedef enum logic [1:0] {
		ST_OK      = 2'd0,
		ST_NO_COMB = 2'd1,
		ST_NO_SLOT = 2'd2,
		ST_BAD_LVL = 2'd3
	} status_t;

	typedef struct packed {
		logic             op;
		logic [1:0]       level;
		logic [EntryW-1:0] entry_in;
		logic [TypeW-1:0] range_type;
		logic [TypeW-1:0] wanted_type;
	} item_t;

	typedef struct packed {
		logic [EntryW-1:0] entry_out;
		logic [SlotW-1:0]  slot_byte;
		logic [1:0]        status;
	} result_t;

	// effective type of a range type and an attribute type; bit 3 set means none
	function automatic logic [TypeW:0] combine(input logic [TypeW-1:0] rng,
			input logic [TypeW-1:0] at);
		logic [TypeW:0] r;
		r = 4'h8;
		case (rng)
			3'd0: begin
				case (at)
					3'd0: r = 4'd0;
					3'd1: r = 4'd1;
					3'd4, 3'd5, 3'd6, 3'd7: r = 4'd0;
					default: r = 4'h8;
				endcase
			end
			3'd1: begin
				case (at)
					3'd0: r = 4'd0;
					3'd1: r = 4'd1;
					3'd4, 3'd5: r = 4'd0;
					3'd6, 3'd7: r = 4'd1;
					default: r = 4'h8;
				endcase
			end
			3'd4: begin
				case (at)
					3'd0: r = 4'd0;
					3'd1: r = 4'd1;
					3'd4: r = 4'd4;
					3'd5: r = 4'd5;
					3'd6: r = 4'd4;
					3'd7: r = 4'd0;
					default: r = 4'h8;
				endcase
			end
			3'd5: begin
				case (at)
					3'd0: r = 4'd0;
					3'd1: r = 4'd1;
					3'd4: r = 4'd4;
					3'd5: r = 4'd5;
					3'd6: r = 4'd5;
					3'd7: r = 4'd1;
					default: r = 4'h8;
				endcase
			end
			3'd6: begin
				case (at)
					3'd0: r = 4'd0;
					3'd1: r = 4'd1;
					3'd4: r = 4'd4;
					3'd5: r = 4'd5;
					3'd6: r = 4'd6;
					3'd7: r = 4'd0;
					default: r = 4'h8;
				endcase
			end
			default: r = 4'h8;
		endcase
		return r;
	endfunction

endpackage

// File: design/page_memory_type_selector_unit.sv
// Page memory type selector.
// Item channel (item_valid / item_stall / item): one page table entry with its
// level, range type, requested type and mode (set or get) per transfer.
// Result channel (result_valid / result_stall / result): the rewritten or
// unchanged entry, the selected slot byte in get mode and a status code.
// Config channel (cfg_valid / cfg_ready / cfg_data): the 64-bit attribute slot
// table; cfg_ready is always high, write only while the block is idle.
// An accepted item is captured in the input register, passes one pass of table
// lookup and two eight-way priority matches, and is then loaded into the result
// register, from which it is transferred. Throughput is one item per cycle
// while result_stall is low.
// While result_stall is held the result stays put; the input register still
// takes one more item, after which item_stall rises until the result moves.
// Reset empties both registers and loads the slot table with its default
// value; no clearing pass is needed.
module page_memory_type_selector_unit (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              item_valid,
	output logic              item_stall,
	input  pmts_pkg::item_t   item,
	output logic              result_valid,
	input  logic              result_stall,
	output pmts_pkg::result_t result,
	input  logic              cfg_valid,
	output logic              cfg_ready,
	input  logic [63:0]       cfg_data
);
	import pmts_pkg::*;

	logic [PatW-1:0] pat_q;
	logic            valid_s1;
	item_t           item_s1;
	logic            valid_s2;
	result_t         result_s2;
	logic            s2_free;
	logic            s1_free;
	result_t         res_c;

	logic [NumSlots-1:0] at_hit;
	logic [NumSlots-1:0] slot_hit;
	logic [IdxW-1:0]     at_sel;
	logic [IdxW-1:0]     slot_sel;
	logic                at_found;
	logic                slot_found;
	logic [IdxW-1:0]     get_idx;
	logic [EntryW-1:0]   clr_mask;
	logic [EntryW-1:0]   set_bits;
	logic                small_page;

	assign cfg_ready = 1'b1;
	assign s2_free = !valid_s2 || !result_stall;
	assign s1_free = !valid_s1 || s2_free;
	assign item_stall = !s1_free;
	assign result_valid = valid_s2;
	assign result = result_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pat_q <= PAT_RESET;
		end else if (cfg_valid && cfg_ready) begin
			pat_q <= cfg_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (s1_free)
				valid_s1 <= item_valid;
			if (s2_free)
				valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (s1_free && item_valid)
			item_s1 <= item;
		if (s2_free && valid_s1)
			result_s2 <= res_c;
	end

	// first attribute type giving the wanted type, first slot holding it
	always_comb begin
		for (int i = 0; i < NumSlots; i++) begin
			at_hit[i] = (combine(item_s1.range_type, IdxW'(i)) == {1'b0, item_s1.wanted_type});
		end
	end

	always_comb begin
		for (int i = 0; i < NumSlots; i++) begin
			slot_hit[i] = (pat_q[i*SlotW +: TypeW] == at_sel);
		end
	end

	always_comb begin
		at_sel = '0;
		at_found = 1'b0;
		for (int i = NumSlots - 1; i >= 0; i--) begin
			if (at_hit[i]) begin
				at_sel = IdxW'(i);
				at_found = 1'b1;
			end
		end
	end

	always_comb begin
		slot_sel = '0;
		slot_found = 1'b0;
		for (int i = NumSlots - 1; i >= 0; i--) begin
			if (slot_hit[i]) begin
				slot_sel = IdxW'(i);
				slot_found = 1'b1;
			end
		end
	end

	always_comb begin
		small_page = (item_s1.level == LVL_4K);
		get_idx = {small_page ? item_s1.entry_in[BIT_PAT_SMALL] : item_s1.entry_in[BIT_PAT_LARGE],
			item_s1.entry_in[BIT_PCD], item_s1.entry_in[BIT_PWT]};
		clr_mask = '0;
		clr_mask[BIT_PWT] = 1'b1;
		clr_mask[BIT_PCD] = 1'b1;
		if (small_page)
			clr_mask[BIT_PAT_SMALL] = 1'b1;
		else
			clr_mask[BIT_PAT_LARGE] = 1'b1;
		set_bits = '0;
		set_bits[BIT_PWT] = slot_sel[0];
		set_bits[BIT_PCD] = slot_sel[1];
		if (small_page)
			set_bits[BIT_PAT_SMALL] = slot_sel[2];
		else
			set_bits[BIT_PAT_LARGE] = slot_sel[2];

		res_c.entry_out = item_s1.entry_in;
		res_c.slot_byte = '0;
		res_c.status = ST_OK;
		if (item_s1.level == LVL_BAD) begin
			res_c.status = ST_BAD_LVL;
		end else if (item_s1.op == OP_GET) begin
			res_c.slot_byte = pat_q[get_idx*SlotW +: SlotW];
		end else if (!at_found) begin
			res_c.status = ST_NO_COMB;
		end else if (!slot_found) begin
			res_c.status = ST_NO_SLOT;
		end else begin
			res_c.entry_out = (item_s1.entry_in & ~clr_mask) | set_bits;
		end
	end

endmodule

// File: design/pmts_checker.sv
module pmts_checker (
	input logic              clk,
	input logic              arst_n,
	input logic              item_valid,
	input logic              item_stall,
	input logic              result_valid,
	input logic              result_stall,
	input pmts_pkg::result_t result,
	input logic              cfg_ready
);
	import pmts_pkg::*;

	// stalled result holds
	a_result_hold: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result_stall |=> result_valid && $stable(result))
		else $error("result changed under stall");

	// input back-pressure only comes from a stalled result
	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		item_stall |-> result_valid && result_stall)
		else $error("item stalled without output back-pressure");

	// an accepted item reaches the result register when the output drains
	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		item_valid && !item_stall ##1 !result_stall |=> result_valid)
		else $error("accepted item did not reach the result register");

	// slot byte only on a good result
	a_slot_zero: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result.status != ST_OK |-> result.slot_byte == '0 && cfg_ready)
		else $error("slot byte set on failed result");

endmodule

bind page_memory_type_selector_unit pmts_checker u_pmts_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.item_valid   (item_valid),
	.item_stall   (item_stall),
	.result_valid (result_valid),
	.result_stall (result_stall),
	.result       (result),
	.cfg_ready    (cfg_ready)
);

// File: bench/pmts_bench_pkg.sv
`timescale 1ns / 100ps

package pmts_bench_pkg;

	import pmts_pkg::*;

	localparam logic [3:0] NO_TYPE = 4'h8;

	class memtype_checker;

		logic [PatW-1:0] slots;
		bit [3:0]        effective [8][8];
		result_t         awaited [$];
		int unsigned     mismatches;
		int unsigned     checked;

		function new();
			slots = PAT_RESET;
			mismatches = 0;
			checked = 0;
			// effective type by [range type][attribute type]
			effective = '{
				'{4'd0, 4'd1, NO_TYPE, NO_TYPE, 4'd0, 4'd0, 4'd0, 4'd0},
				'{4'd0, 4'd1, NO_TYPE, NO_TYPE, 4'd0, 4'd0, 4'd1, 4'd1},
				'{NO_TYPE, NO_TYPE, NO_TYPE, NO_TYPE, NO_TYPE, NO_TYPE, NO_TYPE, NO_TYPE},
				'{NO_TYPE, NO_TYPE, NO_TYPE, NO_TYPE, NO_TYPE, NO_TYPE, NO_TYPE, NO_TYPE},
				'{4'd0, 4'd1, NO_TYPE, NO_TYPE, 4'd4, 4'd5, 4'd4, 4'd0},
				'{4'd0, 4'd1, NO_TYPE, NO_TYPE, 4'd4, 4'd5, 4'd5, 4'd1},
				'{4'd0, 4'd1, NO_TYPE, NO_TYPE, 4'd4, 4'd5, 4'd6, 4'd0},
				'{NO_TYPE, NO_TYPE, NO_TYPE, NO_TYPE, NO_TYPE, NO_TYPE, NO_TYPE, NO_TYPE}
			};
		endfunction

		function void load_slots(logic [PatW-1:0] v);
			slots = v;
		endfunction

		function int pending();
			return awaited.size();
		endfunction

		function result_t mem_type_outcome(item_t it);
			result_t     r;
			int unsigned pbit;
			logic [2:0]  idx;
			logic [2:0]  attr;
			logic [2:0]  sl;
			bit          hit_attr;
			bit          hit_slot;
			r.entry_out = it.entry_in;
			r.slot_byte = '0;
			r.status = ST_OK;
			attr = '0;
			sl = '0;
			hit_attr = 1'b0;
			hit_slot = 1'b0;
			if (it.level == LVL_BAD) begin
				r.status = ST_BAD_LVL;
			end else begin
				pbit = (it.level == LVL_4K) ? BIT_PAT_SMALL : BIT_PAT_LARGE;
				if (it.op == OP_GET) begin
					idx = {it.entry_in[pbit], it.entry_in[BIT_PCD], it.entry_in[BIT_PWT]};
					r.slot_byte = slots[idx*8 +: 8];
				end else begin
					for (int i = 0; i < 8; i++)
						if (!hit_attr && effective[it.range_type][i] == {1'b0, it.wanted_type}) begin
							attr = i[2:0];
							hit_attr = 1'b1;
						end
					if (!hit_attr) begin
						r.status = ST_NO_COMB;
					end else begin
						for (int i = 0; i < 8; i++)
							if (!hit_slot && slots[i*8 +: 3] == attr) begin
								sl = i[2:0];
								hit_slot = 1'b1;
							end
						if (!hit_slot) begin
							r.status = ST_NO_SLOT;
						end else begin
							r.entry_out[BIT_PWT] = sl[0];
							r.entry_out[BIT_PCD] = sl[1];
							r.entry_out[pbit] = sl[2];
						end
					end
				end
			end
			return r;
		endfunction

		function void note_item(item_t it);
			awaited.push_back(mem_type_outcome(it));
		endfunction

		function void check_result(result_t got);
			result_t want;
			if (awaited.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("%0t: result with nothing outstanding: entry %h slot %h status %0d",
						$realtime, got.entry_out, got.slot_byte, got.status);
				return;
			end
			want = awaited.pop_front();
			checked++;
			if (got.entry_out !== want.entry_out || got.slot_byte !== want.slot_byte ||
					got.status !== want.status) begin
				mismatches++;
				if (mismatches <= 10)
					$display("%0t: result %0d wrong: expected entry %h slot %h status %0d, got entry %h slot %h status %0d",
						$realtime, checked, want.entry_out, want.slot_byte, want.status,
						got.entry_out, got.slot_byte, got.status);
			end
		endfunction

	endclass

endpackage

// File: bench/page_memory_type_selector_unit_test.sv
`timescale 1ns / 100ps

module page_memory_type_selector_unit_test;

	import pmts_pkg::*;
	import pmts_bench_pkg::*;

	localparam int unsigned CYCLE_LIMIT = 200000;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        item_valid = 1'b0;
	logic        item_stall;
	item_t       item = '0;
	logic        result_valid;
	logic        result_stall = 1'b0;
	result_t     result;
	logic        cfg_valid = 1'b0;
	logic        cfg_ready;
	logic [63:0] cfg_data = '0;

	memtype_checker sb = new();

	int unsigned tx_idle_pct = 0;
	int unsigned rx_idle_pct = 0;
	int unsigned transfers = 0;
	int unsigned settings = 0;
	int unsigned cycles = 0;
	bit          rx_hold = 1'b0;
	bit          pressure_go = 1'b0;

	page_memory_type_selector_unit DUT (
		.clk          (clk),
		.arst_n       (arst_n),
		.item_valid   (item_valid),
		.item_stall   (item_stall),
		.item         (item),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.result       (result),
		.cfg_valid    (cfg_valid),
		.cfg_ready    (cfg_ready),
		.cfg_data     (cfg_data)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("Mismatches found");
			$finish;
		end
	end

	// result side: check the transfer, then pick next stall
	always @(posedge clk) begin
		if (result_valid === 1'b1 && result_stall === 1'b0)
			sb.check_result(result);
		result_stall <= rx_hold || ($urandom_range(99) < rx_idle_pct);
	end

	// long receiver hold-off so the block backs up into its input
	initial begin
		wait (pressure_go);
		@(posedge clk);
		rx_hold <= 1'b1;
		repeat (80) @(posedge clk);
		rx_hold <= 1'b0;
	end

	function automatic item_t mk(logic op, logic [1:0] lvl, logic [63:0] e,
			logic [2:0] rng, logic [2:0] want);
		item_t it;
		it.op = op;
		it.level = lvl;
		it.entry_in = e;
		it.range_type = rng;
		it.wanted_type = want;
		return it;
	endfunction

	// a defined memory type; UC- optional
	function automatic logic [2:0] pick_type(bit with_ucm);
		case ($urandom_range(with_ucm ? 5 : 4))
			0: return 3'd0;
			1: return 3'd1;
			2: return 3'd4;
			3: return 3'd5;
			4: return 3'd6;
			default: return 3'd7;
		endcase
	endfunction

	task automatic send_item(input item_t it);
		while ($urandom_range(99) < tx_idle_pct) begin
			item_valid <= 1'b0;
			@(posedge clk);
		end
		item_valid <= 1'b1;
		item <= it;
		do @(posedge clk); while (item_stall !== 1'b0);
		sb.note_item(it);
		transfers++;
	endtask

	task automatic drain();
		item_valid <= 1'b0;
		while (sb.pending() != 0) @(posedge clk);
	endtask

	task automatic write_slots(input logic [63:0] v);
		cfg_valid <= 1'b1;
		cfg_data <= v;
		do @(posedge clk); while (cfg_ready !== 1'b1);
		cfg_valid <= 1'b0;
		sb.load_slots(v);
		settings++;
	endtask

	initial begin
		logic [63:0] e;
		logic [63:0] tbl;
		logic [7:0]  b;
		logic [1:0]  lvl;
		logic [2:0]  rng;
		logic [2:0]  want;
		int unsigned n;

		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		tx_idle_pct = 6;
		rx_idle_pct = 49;

		// directed, default slot table: types 6 4 7 0 6 4 7 0
		send_item(mk(OP_SET, LVL_1G, 64'h0, 3'd6, 3'd6));
		send_item(mk(OP_SET, LVL_4K, '1, 3'd6, 3'd0));
		send_item(mk(OP_SET, LVL_2M, '1, 3'd4, 3'd4));
		send_item(mk(OP_SET, LVL_1G, '1, 3'd5, 3'd5));   // no slot holds WP
		send_item(mk(OP_SET, LVL_4K, 64'h0, 3'd0, 3'd1)); // no slot holds WC
		send_item(mk(OP_SET, LVL_2M, 64'h5555_aaaa_5555_aaaa, 3'd1, 3'd7));
		send_item(mk(OP_SET, LVL_1G, 64'h0123_4567_89ab_cdef, 3'd2, 3'd0));
		send_item(mk(OP_SET, LVL_4K, '1, 3'd3, 3'd0));
		send_item(mk(OP_SET, LVL_2M, '1, 3'd7, 3'd6));
		send_item(mk(OP_SET, LVL_1G, '1, 3'd6, 3'd2));
		send_item(mk(OP_SET, LVL_4K, 64'h0, 3'd4, 3'd3));
		send_item(mk(OP_SET, LVL_BAD, '1, 3'd6, 3'd6));
		send_item(mk(OP_GET, LVL_BAD, '1, 3'd0, 3'd0));
		send_item(mk(OP_SET, LVL_1G, '1, 3'd1, 3'd7));
		for (int i = 0; i < 8; i++) begin
			e = {$urandom, $urandom};
			lvl = (i % 2 == 0) ? LVL_4K : ((i % 4 == 1) ? LVL_1G : LVL_2M);
			e[BIT_PWT] = i[0];
			e[BIT_PCD] = i[1];
			if (lvl == LVL_4K)
				e[BIT_PAT_SMALL] = i[2];
			else
				e[BIT_PAT_LARGE] = i[2];
			send_item(mk(OP_GET, lvl, e, 3'($urandom), 3'($urandom)));
		end
		drain();

		// extremes of the slot table, then random tables
		for (int p = 0; p < 8; p++) begin
			if (p == 0) begin
				tbl = '1;
			end else if (p == 1) begin
				tbl = '0;
			end else begin
				for (int s = 0; s < 8; s++) begin
					b = 8'($urandom_range(255));
					if ($urandom_range(9) != 0)
						b[2:0] = pick_type(1'b1);
					tbl[s*8 +: 8] = b;
				end
			end
			if (p < 4) begin
				tx_idle_pct = 6;
				rx_idle_pct = 49;
			end else if (p < 6) begin
				tx_idle_pct = 49;
				rx_idle_pct = 6;
			end else begin
				tx_idle_pct = 0;
				rx_idle_pct = 0;
			end
			write_slots(tbl);
			if (p == 6)
				pressure_go = 1'b1;
			n = (p < 2) ? 50 : 100;
			for (int k = 0; k < n; k++) begin
				lvl = ($urandom_range(9) == 0) ? LVL_BAD : 2'($urandom_range(2));
				rng = ($urandom_range(6) == 0) ? 3'($urandom) : pick_type(1'b0);
				if (rng == 3'd7)
					rng = 3'd6;
				want = ($urandom_range(6) == 0) ? 3'($urandom) : pick_type(1'b1);
				send_item(mk(1'($urandom), lvl, {$urandom, $urandom}, rng, want));
			end
			drain();
		end

		repeat (10) @(posedge clk);
		$display("Checked %0d results from %0d item transfers under %0d slot table writes",
			sb.checked, transfers, settings);
		$display("set and get at all levels, reserved types, both idle mixes, long result hold-off");
		if (sb.mismatches == 0 && sb.pending() == 0)
			$display("No mismatches found");
		else
			$display("Mismatches found");
		$finish;
	end

endmodule

// File: files.f
design/pmts_pkg.sv
design/page_memory_type_selector_unit.sv
design/pmts_checker.sv
bench/pmts_bench_pkg.sv
bench/page_memory_type_selector_unit_test.sv
